@@ hdl/booth_signed_multiplier_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef BOOTH_SIGNED_MULTIPLIER_MACROS_SVH
`define BOOTH_SIGNED_MULTIPLIER_MACROS_SVH

// Clocked check, idle while reset is high.
`define BSM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BSM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/bsm_pkg.sv @@
`default_nettype none

package bsm_pkg;

   localparam int WIDTH_DEFAULT = 16;

   // Booth pair: current multiplier bit, then the bit below it.
   typedef enum logic [1:0] {
      BOOTH_ZERO = 2'b00,
      BOOTH_ADD  = 2'b01,
      BOOTH_SUB  = 2'b10,
      BOOTH_RUN  = 2'b11
   } booth_pair_type;

endpackage

`default_nettype wire

@@ hdl/bsm_if.sv @@
`default_nettype none

interface bsm_req_if #(
   parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] multiplicand;
   logic signed [WIDTH-1:0] multiplier;

   modport source (output valid, output multiplicand, output multiplier, input ready);
   modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_rsp_if #(
   parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT
);
   logic                      valid;
   logic                      ready;
   logic signed [2*WIDTH-1:0] product;

   modport source (output valid, output product, input ready);
   modport sink   (input valid, input product, output ready);
endinterface

`default_nettype wire

@@ hdl/booth_signed_multiplier.sv @@
// Signed radix-2 Booth multiplier.
//
// req_if carries a WIDTH-bit signed multiplicand and multiplier; rsp_if
// returns their exact signed product of 2*WIDTH bits, one product per
// request beat, in request order. Both channels move a beat on a rising
// clock edge where valid and ready are high.
//
// The datapath is a chain of WIDTH register stages, each doing one Booth
// step (add or subtract the shifted multiplicand, or keep the sum) for one
// multiplier bit. A new request can enter every cycle unless a stalled
// receiver has backed the pipeline up to req_if.ready.
//
// Reset (synchronous, active high) clears every stage's valid bit, so the
// pipeline comes out empty. When the receiver holds rsp_if.ready low, the
// last stage holds its product and earlier stages keep filling behind it;
// req_if.ready drops only once all WIDTH stages are occupied.
`default_nettype none

module booth_signed_multiplier #(
   parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   bsm_req_if.sink  req_if,
   bsm_rsp_if.source rsp_if
);

   logic [WIDTH:0]          stage_valid;
   logic [WIDTH:0]          stage_ready;
   logic signed [WIDTH-1:0] stage_mcand  [0:WIDTH];
   logic [WIDTH-1:0]        stage_mplier [0:WIDTH];
   logic [2*WIDTH-1:0]      stage_acc    [0:WIDTH];

   assign stage_valid[0]  = req_if.valid;
   assign req_if.ready    = stage_ready[0];
   assign stage_mcand[0]  = req_if.multiplicand;
   assign stage_mplier[0] = req_if.multiplier;
   assign stage_acc[0]    = '0;

   for (genvar k = 0; k < WIDTH; k++) begin : g_stage
      bsm_stage #(
         .WIDTH (WIDTH),
         .BIT   (k)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (stage_valid[k]),
         .in_ready   (stage_ready[k]),
         .in_mcand   (stage_mcand[k]),
         .in_mplier  (stage_mplier[k]),
         .in_acc     (stage_acc[k]),
         .out_valid  (stage_valid[k+1]),
         .out_ready  (stage_ready[k+1]),
         .out_mcand  (stage_mcand[k+1]),
         .out_mplier (stage_mplier[k+1]),
         .out_acc    (stage_acc[k+1])
      );
   end

   assign stage_ready[WIDTH] = rsp_if.ready;
   assign rsp_if.valid       = stage_valid[WIDTH];
   assign rsp_if.product     = stage_acc[WIDTH];

endmodule

`default_nettype wire

@@ hdl/bsm_stage.sv @@
`default_nettype none

module bsm_stage #(
   parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT,
   parameter int BIT   = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [WIDTH-1:0] in_mcand,
   input  logic [WIDTH-1:0]        in_mplier,
   input  logic [2*WIDTH-1:0]      in_acc,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [WIDTH-1:0] out_mcand,
   output logic [WIDTH-1:0]        out_mplier,
   output logic [2*WIDTH-1:0]      out_acc
);
   import bsm_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   logic signed [WIDTH-1:0] mcand_ff;
   logic [WIDTH-1:0]        mplier_ff;
   logic [2*WIDTH-1:0]      acc_ff;
   logic [2*WIDTH-1:0]      acc_in;
   logic [2*WIDTH-1:0]      term;
   logic                    prev_bit;
   logic                    load;
   booth_pair_type          pair;

   if (BIT == 0) begin : g_first
      assign prev_bit = 1'b0;
   end else begin : g_rest
      assign prev_bit = in_mplier[BIT-1];
   end

   assign pair     = booth_pair_type'({in_mplier[BIT], prev_bit});
   assign term     = {{WIDTH{in_mcand[WIDTH-1]}}, in_mcand} << BIT;
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      unique case (pair)
         BOOTH_SUB: acc_in = in_acc - term;
         BOOTH_ADD: acc_in = in_acc + term;
         BOOTH_ZERO,
         BOOTH_RUN: acc_in = in_acc;
      endcase
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the beat until the next stage takes it.
   always_ff @(posedge clock) begin
      if (load) begin
         mcand_ff  <= in_mcand;
         mplier_ff <= in_mplier;
         acc_ff    <= acc_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_mcand  = mcand_ff;
   assign out_mplier = mplier_ff;
   assign out_acc    = acc_ff;

endmodule

`default_nettype wire

@@ hdl/bsm_checker.sv @@
`default_nettype none
`include "booth_signed_multiplier_macros.svh"

module bsm_checker #(
   parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [2*WIDTH-1:0] rsp_product
);

   localparam int CountWidth = $clog2(WIDTH + 2);

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  rsp_stall;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // Track beats in flight: requests taken minus products delivered.
   always_comb begin
      count_in = count_ff;
      if (req_fire && !rsp_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `BSM_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid, "product valid after reset")
   `BSM_ASSERT(a_no_phantom, rsp_valid |-> (count_ff != '0), "product with no request in flight")
   `BSM_ASSERT(a_depth, count_ff <= CountWidth'(WIDTH), "more beats in flight than stages")
   `BSM_ASSERT(a_hold, rsp_stall |=> (rsp_valid && $stable(rsp_product)), "stalled product lost")

endmodule

bind booth_signed_multiplier bsm_checker #(
   .WIDTH (WIDTH)
) u_bsm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_product (rsp_if.product)
);

`default_nettype wire

@@ test/tb_booth_signed_multiplier.sv @@
module tb_booth_signed_multiplier;
   timeunit 1ns;
   timeprecision 1ps;

   import bsm_pkg::*;

   localparam int WIDTH      = WIDTH_DEFAULT;
   localparam int HOLD_BEATS = 300;
   localparam int STALL_MAX  = 3000;
   localparam int PHASE_LEN  = 440;
   localparam int N_DIRECTED = 17;

   typedef logic signed [WIDTH-1:0]   operand_type;
   typedef logic signed [2*WIDTH-1:0] product_type;

   typedef struct packed {
      operand_type mcand;
      operand_type mplier;
      logic        known;
      product_type product;
   } mult_case_type;

   logic clock;
   logic reset;

   bsm_req_if #(.WIDTH(WIDTH)) req_if ();
   bsm_rsp_if #(.WIDTH(WIDTH)) rsp_if ();

   booth_signed_multiplier #(.WIDTH(WIDTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   product_type pending_products [$];
   int          error_count    = 0;
   int          idle_cycles    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_req       = 0;

   // Directed rows: a product is typed in where it is plain from the operands.
   mult_case_type directed_cases [N_DIRECTED] = '{
      '{16'sh0000, 16'sh0000, 1'b1, 32'sh0000_0000},
      '{16'sh8000, 16'sh8000, 1'b1, 32'sh4000_0000},
      '{16'sh8000, 16'sh7FFF, 1'b1, 32'shC000_8000},
      '{16'sh7FFF, 16'sh8000, 1'b1, 32'shC000_8000},
      '{16'sh7FFF, 16'sh7FFF, 1'b1, 32'sh3FFF_0001},
      '{16'shFFFF, 16'shFFFF, 1'b1, 32'sh0000_0001},
      '{16'sh0001, 16'shFFFF, 1'b1, 32'shFFFF_FFFF},
      '{16'sh8000, 16'sh0001, 1'b1, 32'shFFFF_8000},
      '{16'sh8000, 16'shFFFF, 1'b1, 32'sh0000_8000},
      '{16'sh0000, 16'sh8000, 1'b1, 32'sh0000_0000},
      '{16'sh5555, 16'shAAAA, 1'b0, 32'sh0},
      '{16'shAAAA, 16'sh5555, 1'b0, 32'sh0},
      '{16'sh3039, 16'shE57B, 1'b0, 32'sh0},
      '{16'sh00FF, 16'sh0F0F, 1'b0, 32'sh0},
      '{16'shFFFE, 16'sh0003, 1'b0, 32'sh0},
      '{16'sh0003, 16'sh8001, 1'b0, 32'sh0},
      '{16'shF00F, 16'sh7FFE, 1'b0, 32'sh0}
   };

   // Walk the multiplier bits with the bit below, add or subtract the
   // weighted multiplicand; the sum wraps at the product width.
   function automatic product_type booth_product(operand_type mcand, operand_type mplier);
      product_type    acc;
      product_type    term;
      logic           prev;
      booth_pair_type pair;
      acc  = '0;
      prev = 1'b0;
      for (int i = 0; i < WIDTH; i++) begin
         term = product_type'(mcand) <<< i;
         pair = booth_pair_type'({mplier[i], prev});
         case (pair)
            BOOTH_SUB: acc = acc - term;
            BOOTH_ADD: acc = acc + term;
            default: ;
         endcase
         prev = mplier[i];
      end
      return acc;
   endfunction

   // Lean on the extremes and short runs of ones so the Booth pairs vary.
   function automatic operand_type pick_operand();
      case ($urandom_range(9))
         0: return {1'b1, {(WIDTH-1){1'b0}}};
         1: return {1'b0, {(WIDTH-1){1'b1}}};
         2: return '0;
         3: return '1;
         4: return operand_type'($signed($urandom_range(15)) - 8);
         default: return operand_type'($urandom);
      endcase
   endfunction

   task automatic note_failure(string what, product_type want, product_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic send_item(operand_type mcand, operand_type mplier, product_type product);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.multiplicand <= mcand;
      req_if.multiplier   <= mplier;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      pending_products.insert(pending_products.size(), product);
   endtask

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen    = 0;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_BEATS;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Score each product beat and watch for a stuck pipeline.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_products.size() == 0)
               note_failure("product with nothing pending", 'x, rsp_if.product);
            else if (rsp_if.product !== pending_products[0])
               note_failure("product mismatch", pending_products.pop_front(),
                            rsp_if.product);
            else
               void'(pending_products.pop_front());
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_MAX) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      operand_type mcand;
      operand_type mplier;
      int          idle_mix [4];
      int          stall_mix [4];
      idle_mix  = '{0, 45, 0, 21};
      stall_mix = '{0, 0, 45, 21};

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.multiplicand = '0;
      req_if.multiplier   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         send_item(directed_cases[i].mcand, directed_cases[i].mplier,
                   directed_cases[i].known ? directed_cases[i].product
                      : booth_product(directed_cases[i].mcand, directed_cases[i].mplier));
      end

      // Hold the receiver off so the pipeline fills and backs up into requests.
      hold_req++;
      repeat (50) begin
         mcand  = pick_operand();
         mplier = pick_operand();
         send_item(mcand, mplier, booth_product(mcand, mplier));
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_mix[p];
         recv_stall_pct = stall_mix[p];
         repeat (PHASE_LEN) begin
            mcand  = pick_operand();
            mplier = pick_operand();
            send_item(mcand, mplier, booth_product(mcand, mplier));
         end
      end
      req_if.valid <= 1'b0;

      while (pending_products.size() != 0)
         @(posedge clock);
      repeat (2 * WIDTH) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
